// ----- rtl/dam_pkg.sv -----
// Shared constants and types for the distance attenuation mixer.
// Used by dam_div and distance_attenuation_mixer_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dam_pkg;

    localparam int COORD_W          = 16;
    localparam int EXP_W            = 15;
    localparam int GAIN_W           = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam logic [EXP_W-1:0]  EXP_RESET  = 15'd4096;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_HALF  = 16'd16384;

    // Divider: 2^31 / D with D in [2^16, 2^31 + 2^17), 16 quotient bits.
    localparam int DEN_W        = 32;
    localparam int QUO_W        = 16;
    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = QUO_W / DIV_BITS;
    localparam logic [DEN_W-1:0] DIV_NUMER = 32'h8000_0000;

    // Flags that ride alongside the divider.
    typedef struct packed {
        logic szero;   // source and listener coincide
        logic gzero;   // power term overflowed, gain flushes to zero
    } gflag_t;

endpackage

`default_nettype wire

// ----- rtl/distance_attenuation_mixer_top.sv -----
// Top level of the distance attenuation mixer: distance, power law gain, mix.
// Depends on dam_pkg and dam_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  source_*, listener_*, samples, mix_*_in
// output    out        out_valid/out_stall  mix_left_out, mix_right_out, gain
// config    in         cfg_valid/cfg_ready  cfg_data (distance_exponent)
//
// The pipeline takes one item per cycle while it is not stalled. It has 17 register
// stages, eight of them in the divider that forms the gain.
// Reset clears all valid bits and loads the exponent with 1.0 (4096).
// The whole pipeline holds while a result waits at a stalled output, so
// in_stall is high exactly when out_valid and out_stall are both high.
// The config port is always ready; write it only while the pipeline is empty.

module distance_attenuation_mixer_top
    import dam_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [COORD_W-1:0]      source_x,
    input  wire logic signed [COORD_W-1:0]      source_y,
    input  wire logic signed [COORD_W-1:0]      source_z,
    input  wire logic signed [COORD_W-1:0]      listener_x,
    input  wire logic signed [COORD_W-1:0]      listener_y,
    input  wire logic signed [COORD_W-1:0]      listener_z,
    input  wire logic signed [SAMPLE_WIDTH-1:0] left_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] right_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] mix_left_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] mix_right_in,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      mix_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]      mix_right_out,
    output logic        [GAIN_W-1:0]            gain,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [EXP_W-1:0]               cfg_data
);

    // Stage map: 0 differences, 1 squares, 2 sum, 3 log2, 4 exponent product,
    // 5 exp2 and denominator, 6..13 divider, 14 gain, 15 scale, 16 output.
    localparam int ST_DIV0 = 6;
    localparam int ST_GAIN = ST_DIV0 + DIV_STAGES;
    localparam int ST_MAG  = ST_GAIN + 1;
    localparam int NST     = ST_MAG + 2;
    localparam int DW      = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int P_W     = $clog2(SUM_W);
    localparam int L_W     = 23;
    localparam int PROD_W  = L_W + EXP_W + 1;
    localparam int Y_W     = PROD_W - 13;
    localparam int N_W     = Y_W - 16;
    localparam int M_W     = 17;
    localparam int MAG_W   = SAMPLE_WIDTH + 1;
    localparam int SUMS_W  = SAMPLE_WIDTH + 3;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] l;
        logic signed [SAMPLE_WIDTH-1:0] r;
        logic signed [SAMPLE_WIDTH-1:0] ml;
        logic signed [SAMPLE_WIDTH-1:0] mr;
    } smp_t;

    logic              en;
    logic [NST-1:0]    v_reg;
    logic [EXP_W-1:0]  exp_reg;

    logic signed [DW-1:0]    dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0]        s_reg;
    logic signed [L_W-1:0]   l_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]        den_reg;
    gflag_t                  fl_reg [ST_GAIN-2:2];
    smp_t                    smp_reg [ST_MAG-1:0];
    logic [GAIN_W-1:0]       gain_reg;
    logic [GAIN_W-1:0]       gain2_reg;
    logic [MAG_W-1:0]        magl_reg, magr_reg;
    smp_t                    smpm_reg;

    logic signed [SAMPLE_WIDTH-1:0] outl_reg, outr_reg;
    logic [GAIN_W-1:0]              outg_reg;

    logic [QUO_W-1:0]        quo;

    assign en        = !(v_reg[NST-1] && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_reg <= EXP_RESET;
        else if (cfg_valid && cfg_ready)
            exp_reg <= cfg_data;
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    // Leading one search and Mitchell log2 of the squared distance.
    logic [P_W-1:0]        p_w;
    logic [SUM_W-1:0]      norm_w;
    logic signed [6:0]     lexp_w;
    logic signed [L_W-1:0] l_next;

    always_comb
    begin
        p_w = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            if (s_reg[i])
                p_w = P_W'(i);
        end
        norm_w = s_reg << (P_W'(SUM_W - 1) - p_w);
        lexp_w = $signed({1'b0, p_w}) - 7'sd16;
        l_next = {lexp_w, norm_w[SUM_W-2 -: 16]};
    end

    // Mitchell exp2 of e*log2(d) and the divider denominator.
    logic signed [PROD_W-1:0] prod_next;
    logic signed [Y_W-1:0]    y_w;
    logic signed [N_W-1:0]    n_w;
    logic signed [N_W-1:0]    nneg_w;
    logic [M_W-1:0]           m_w;
    logic [DEN_W-1:0]         pw_w;
    logic                     gz_w;

    assign prod_next = $signed({1'b0, exp_reg}) * l_reg;

    always_comb
    begin
        y_w    = prod_reg[PROD_W-1:13];
        n_w    = y_w[Y_W-1:16];
        nneg_w = -n_w;
        m_w    = {1'b1, y_w[15:0]};
        gz_w   = (n_w >= N_W'(15));
        if (n_w >= 0)
            pw_w = DEN_W'({15'b0, m_w} << n_w[3:0]);
        else if (n_w >= -N_W'(20))
            pw_w = DEN_W'(m_w >> nneg_w[4:0]);
        else
            pw_w = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= $signed({source_x[COORD_W-1], source_x})
                      - $signed({listener_x[COORD_W-1], listener_x});
            dy_reg   <= $signed({source_y[COORD_W-1], source_y})
                      - $signed({listener_y[COORD_W-1], listener_y});
            dz_reg   <= $signed({source_z[COORD_W-1], source_z})
                      - $signed({listener_z[COORD_W-1], listener_z});
            sqx_reg  <= SQ_W'(dx_reg * dx_reg);
            sqy_reg  <= SQ_W'(dy_reg * dy_reg);
            sqz_reg  <= SQ_W'(dz_reg * dz_reg);
            s_reg    <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
            l_reg    <= l_next;
            fl_reg[2] <= '{szero: (s_reg == '0), gzero: 1'b0};
            prod_reg <= prod_next;
            fl_reg[3] <= fl_reg[2];
            den_reg  <= DEN_W'(65536) + pw_w;
            fl_reg[4] <= '{szero: fl_reg[3].szero, gzero: gz_w};
            for (int k = 5; k <= ST_GAIN - 2; k++)
                fl_reg[k] <= fl_reg[k-1];
            smp_reg[0] <= '{l: left_sample, r: right_sample,
                            ml: mix_left_in, mr: mix_right_in};
            for (int k = 1; k < ST_MAG; k++)
                smp_reg[k] <= smp_reg[k-1];
        end
    end

    dam_div u_div
    (
        .clk (clk),
        .en  (en),
        .den (den_reg),
        .quo (quo)
    );

    // Gain selection, with coincident positions and overflow handled here.
    logic [GAIN_W-1:0] gain_next;

    always_comb
    begin
        if (fl_reg[ST_GAIN-2].szero)
            gain_next = (exp_reg == '0) ? GAIN_HALF : GAIN_UNITY;
        else if (fl_reg[ST_GAIN-2].gzero)
            gain_next = '0;
        else
            gain_next = quo;
    end

    // Magnitude scaling: |sample| * gain >> 15.
    logic [SAMPLE_WIDTH-1:0]        absl_w, absr_w;
    logic [SAMPLE_WIDTH+GAIN_W-1:0] pl_w, pr_w;

    always_comb
    begin
        absl_w = smp_reg[ST_MAG-1].l[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-smp_reg[ST_MAG-1].l)
                                                    : SAMPLE_WIDTH'(smp_reg[ST_MAG-1].l);
        absr_w = smp_reg[ST_MAG-1].r[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-smp_reg[ST_MAG-1].r)
                                                    : SAMPLE_WIDTH'(smp_reg[ST_MAG-1].r);
        pl_w   = (SAMPLE_WIDTH+GAIN_W)'(absl_w) * (SAMPLE_WIDTH+GAIN_W)'(gain_reg);
        pr_w   = (SAMPLE_WIDTH+GAIN_W)'(absr_w) * (SAMPLE_WIDTH+GAIN_W)'(gain_reg);
    end

    // Signed add and saturation.
    localparam logic signed [SUMS_W-1:0] SAT_HI = SUMS_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [SUMS_W-1:0] SAT_LO = -SUMS_W'(1 << (SAMPLE_WIDTH - 1));

    logic signed [SUMS_W-1:0]       scl_w, scr_w, suml_w, sumr_w;
    logic signed [SAMPLE_WIDTH-1:0] satl_w, satr_w;

    always_comb
    begin
        scl_w  = smpm_reg.l[SAMPLE_WIDTH-1] ? -$signed(SUMS_W'(magl_reg))
                                            : $signed(SUMS_W'(magl_reg));
        scr_w  = smpm_reg.r[SAMPLE_WIDTH-1] ? -$signed(SUMS_W'(magr_reg))
                                            : $signed(SUMS_W'(magr_reg));
        suml_w = SUMS_W'(smpm_reg.ml) + scl_w;
        sumr_w = SUMS_W'(smpm_reg.mr) + scr_w;
        if (suml_w > SAT_HI)
            satl_w = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (suml_w < SAT_LO)
            satl_w = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            satl_w = suml_w[SAMPLE_WIDTH-1:0];
        if (sumr_w > SAT_HI)
            satr_w = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (sumr_w < SAT_LO)
            satr_w = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            satr_w = sumr_w[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gain_reg  <= gain_next;
            magl_reg  <= pl_w[SAMPLE_WIDTH+GAIN_W-1:15];
            magr_reg  <= pr_w[SAMPLE_WIDTH+GAIN_W-1:15];
            smpm_reg  <= smp_reg[ST_MAG-1];
            gain2_reg <= gain_reg;
            outl_reg  <= satl_w;
            outr_reg  <= satr_w;
            outg_reg  <= gain2_reg;
        end
    end

    assign out_valid     = v_reg[NST-1];
    assign mix_left_out  = outl_reg;
    assign mix_right_out = outr_reg;
    assign gain          = outg_reg;

    // The gain never exceeds unity.
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain <= GAIN_UNITY)
        else $error("gain above unity");

    // A valid item that advances into the gain stage is present there in the next cycle.
    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_reg[ST_GAIN-1]) |=> v_reg[ST_GAIN])
        else $error("valid bit lost in pipeline");

    // A live item headed for the divider never carries a denominator below one.
    a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[5] && !fl_reg[4].szero && !fl_reg[4].gzero) |-> den_reg >= DEN_W'(65536))
        else $error("divider denominator below 2^16");

    // Coincident positions give a gain of half or unity.
    a_szero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_reg[ST_GAIN-1] && fl_reg[ST_GAIN-2].szero)
        |=> (gain_reg == GAIN_UNITY || gain_reg == GAIN_HALF))
        else $error("zero distance gain wrong");

endmodule

`default_nettype wire

// ----- rtl/dam_div.sv -----
// Pipelined restoring divider that forms 2^31 / den, two quotient bits per stage.
// Depends on dam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dam_div
    import dam_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];

    logic [DEN_W-1:0] rem_next [DIV_STAGES];
    logic [DEN_W-1:0] den_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];

    always_comb
    begin
        logic [DEN_W-1:0] r;
        logic [DEN_W-1:0] d;
        logic [QUO_W-1:0] q;
        int               sh;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                r = DIV_NUMER;
                d = den;
                q = '0;
            end
            else
            begin
                r = rem_reg[j-1];
                d = den_reg[j-1];
                q = quo_reg[j-1];
            end
            for (int b = 0; b < DIV_BITS; b++)
            begin
                sh = QUO_W - 1 - j * DIV_BITS - b;
                if ((r >> sh) >= d)
                begin
                    r     = r - (d << sh);
                    q[sh] = 1'b1;
                end
            end
            rem_next[j] = r;
            den_next[j] = d;
            quo_next[j] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < DIV_STAGES; j++)
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_next[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire
